// ----- hw/rtl/dq_pkg.sv -----
package dq_pkg;

   // Operation codes carried in the func field of a request.
   localparam logic [2:0] FUNC_PUSH_FRONT = 3'd0;
   localparam logic [2:0] FUNC_PUSH_BACK  = 3'd1;
   localparam logic [2:0] FUNC_POP_FRONT  = 3'd2;
   localparam logic [2:0] FUNC_POP_BACK   = 3'd3;
   localparam logic [2:0] FUNC_REVERSE    = 3'd4;

   // Error codes reported with every response.
   localparam logic [1:0] ERR_NONE       = 2'd0;
   localparam logic [1:0] ERR_PUSH_FULL  = 2'd1;
   localparam logic [1:0] ERR_POP_EMPTY  = 2'd2;

   // Controller sequence for one transaction.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_LOAD
   } dq_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic exec;
      logic load;
   } dq_cmd_type;

endpackage

// ----- hw/rtl/double_ended_queue.sv -----
// Bounded double-ended queue of DEPTH elements held in a ring buffer with a
// head index, a count and a direction flag; reverse only toggles the flag.
// Each request transaction pushes at either end, pops from either end or
// reverses, and yields one response transaction with the front and back
// elements (zero when empty), the element count and an error code. A push
// onto a full queue or a pop from an empty one reports an error and leaves
// the queue unchanged. Each transaction runs through capture, the queue
// update through the single memory write port, the registered memory read
// of both ends, and the load of the output register, which waits while the
// response side stalls. A new request is accepted the cycle after the
// response is loaded, even while that response still waits.
module double_ended_queue #(
   parameter int DEPTH      = 16,
   parameter int ELEM_WIDTH = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [2:0]                   req_func,
   input  logic [ELEM_WIDTH-1:0]        req_value,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [ELEM_WIDTH-1:0]        rsp_front_value,
   output logic [ELEM_WIDTH-1:0]        rsp_back_value,
   output logic [$clog2(DEPTH+1)-1:0]   rsp_element_count,
   output logic [1:0]                   rsp_error_code
);
   import dq_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);

   dq_cmd_type cmd;

   // Sequencer for one transaction at a time.
   dq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // Ring storage, indices and response registers.
   dq_datapath #(
      .DEPTH      (DEPTH),
      .ELEM_WIDTH (ELEM_WIDTH),
      .CNT_W      (CNT_W)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_func          (req_func),
      .req_value         (req_value),
      .rsp_front_value   (rsp_front_value),
      .rsp_back_value    (rsp_back_value),
      .rsp_element_count (rsp_element_count),
      .rsp_error_code    (rsp_error_code)
   );

endmodule

// ----- hw/rtl/dq_ctrl.sv -----
module dq_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output dq_pkg::dq_cmd_type cmd
);
   import dq_pkg::*;

   dq_state_type state_ff, state_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         rsp_free;

   // The output register can take a new result when empty or being drained.
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign req_stall = (state_ff != ST_IDLE);

   // State register and response valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and datapath commands.
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (rsp_free) begin
               cmd.load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- hw/rtl/dq_datapath.sv -----
module dq_datapath #(
   parameter int DEPTH      = 16,
   parameter int ELEM_WIDTH = 64,
   parameter int CNT_W      = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dq_pkg::dq_cmd_type    cmd,
   input  logic [2:0]            req_func,
   input  logic [ELEM_WIDTH-1:0] req_value,
   output logic [ELEM_WIDTH-1:0] rsp_front_value,
   output logic [ELEM_WIDTH-1:0] rsp_back_value,
   output logic [CNT_W-1:0]      rsp_element_count,
   output logic [1:0]            rsp_error_code
);
   import dq_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int SUM_W = CNT_W + 1;

   // Ring storage; only occupied slots reach the response.
   logic [ELEM_WIDTH-1:0] mem [DEPTH];

   logic [2:0]            func_ff;
   logic [ELEM_WIDTH-1:0] value_ff;
   logic [IDX_W-1:0]      head_ff, head_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  rev_ff, rev_in;
   logic [1:0]            err_ff, err_in;
   logic [ELEM_WIDTH-1:0] first_ff, last_ff;
   logic [ELEM_WIDTH-1:0] front_ff, back_ff;
   logic [CNT_W-1:0]      count_out_ff;
   logic [1:0]            err_out_ff;

   logic                  is_push, is_pop, at_front, to_head;
   logic                  full, empty;
   logic [IDX_W-1:0]      head_dec, head_inc, tail_pos, last_pos;
   logic [SUM_W-1:0]      tail_sum;
   logic                  mem_we;
   logic [IDX_W-1:0]      mem_waddr;

   // Latch the request transaction.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff  <= req_func;
         value_ff <= req_value;
      end
   end

   // Ring index arithmetic.
   always_comb begin
      full     = (count_ff == CNT_W'(DEPTH));
      empty    = (count_ff == '0);
      head_dec = (head_ff == '0) ? IDX_W'(DEPTH - 1) : head_ff - 1'b1;
      head_inc = (head_ff == IDX_W'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
      tail_sum = SUM_W'(head_ff) + SUM_W'(count_ff);
      if (tail_sum >= SUM_W'(DEPTH)) begin
         tail_sum = tail_sum - SUM_W'(DEPTH);
      end
      tail_pos = tail_sum[IDX_W-1:0];
      last_pos = (tail_pos == '0) ? IDX_W'(DEPTH - 1) : tail_pos - 1'b1;
   end

   // Operation decode and state update.
   always_comb begin
      is_push   = (func_ff == FUNC_PUSH_FRONT) || (func_ff == FUNC_PUSH_BACK);
      is_pop    = (func_ff == FUNC_POP_FRONT) || (func_ff == FUNC_POP_BACK);
      at_front  = (func_ff == FUNC_PUSH_FRONT) || (func_ff == FUNC_POP_FRONT);
      to_head   = (at_front != rev_ff);
      head_in   = head_ff;
      count_in  = count_ff;
      rev_in    = rev_ff;
      err_in    = ERR_NONE;
      mem_we    = 1'b0;
      mem_waddr = to_head ? head_dec : tail_pos;
      if (is_push) begin
         if (full) begin
            err_in = ERR_PUSH_FULL;
         end else begin
            mem_we   = cmd.exec;
            count_in = count_ff + 1'b1;
            if (to_head) begin
               head_in = head_dec;
            end
         end
      end else if (is_pop) begin
         if (empty) begin
            err_in = ERR_POP_EMPTY;
         end else begin
            count_in = count_ff - 1'b1;
            if (to_head) begin
               head_in = head_inc;
            end
         end
      end else if (func_ff == FUNC_REVERSE) begin
         if (!empty) begin
            rev_in = !rev_ff;
         end
      end
   end

   // Queue control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
         rev_ff   <= 1'b0;
      end else if (cmd.exec) begin
         head_ff  <= head_in;
         count_ff <= count_in;
         rev_ff   <= rev_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         err_ff <= err_in;
      end
   end

   // Memory: one write port, two registered read ports at the ring ends.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= value_ff;
      end
      first_ff <= mem[head_ff];
      last_ff  <= mem[last_pos];
   end

   // Output register for the response transaction.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         if (empty) begin
            front_ff <= '0;
            back_ff  <= '0;
         end else if (rev_ff) begin
            front_ff <= last_ff;
            back_ff  <= first_ff;
         end else begin
            front_ff <= first_ff;
            back_ff  <= last_ff;
         end
         count_out_ff <= count_ff;
         err_out_ff   <= err_ff;
      end
   end

   assign rsp_front_value   = front_ff;
   assign rsp_back_value    = back_ff;
   assign rsp_element_count = count_out_ff;
   assign rsp_error_code    = err_out_ff;

endmodule

// ----- sim/double_ended_queue_checker.sv -----
// Watches both channels of the double-ended queue. It predicts the front,
// back, count and error code for every accepted request transaction and
// compares each accepted response transaction with the oldest prediction.
module double_ended_queue_checker #(
   parameter int DEPTH      = 16,
   parameter int ELEM_WIDTH = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  logic [2:0]                   req_func,
   input  logic [ELEM_WIDTH-1:0]        req_value,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  logic [ELEM_WIDTH-1:0]        rsp_front_value,
   input  logic [ELEM_WIDTH-1:0]        rsp_back_value,
   input  logic [$clog2(DEPTH+1)-1:0]   rsp_element_count,
   input  logic [1:0]                   rsp_error_code,
   output int                           mismatch_count,
   output int                           outstanding
);
   import dq_pkg::*;

   localparam int COUNT_WIDTH = $clog2(DEPTH + 1);

   // What the queue shows after one transaction.
   typedef struct packed {
      logic [ELEM_WIDTH-1:0]  front;
      logic [ELEM_WIDTH-1:0]  back;
      logic [COUNT_WIDTH-1:0] count;
      logic [1:0]             err_code;
   } deque_view_type;

   // Predicted queue contents.
   logic [ELEM_WIDTH-1:0] ring [DEPTH];
   int                    head;
   int                    held;
   logic                  flipped;

   deque_view_type expected_views [$];
   int                    mismatches;

   // Applies one operation to the predicted queue and returns the new view.
   function automatic deque_view_type apply_operation(input logic [2:0] func,
                                                       input logic [ELEM_WIDTH-1:0] value);
      deque_view_type view;
      logic           at_head;
      logic [ELEM_WIDTH-1:0] first;
      logic [ELEM_WIDTH-1:0] last;
      view.err_code = ERR_NONE;
      case (func)
         FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
            if (held == DEPTH) begin
               view.err_code = ERR_PUSH_FULL;
            end else begin
               // Pushing at the logical front lands at the ring head unless flipped.
               at_head = (func == FUNC_PUSH_FRONT) ^ flipped;
               if (at_head) begin
                  head = (head + DEPTH - 1) % DEPTH;
                  ring[head] = value;
               end else begin
                  ring[(head + held) % DEPTH] = value;
               end
               held++;
            end
         end
         FUNC_POP_FRONT, FUNC_POP_BACK: begin
            if (held == 0) begin
               view.err_code = ERR_POP_EMPTY;
            end else begin
               at_head = (func == FUNC_POP_FRONT) ^ flipped;
               if (at_head) begin
                  head = (head + 1) % DEPTH;
               end
               held--;
            end
         end
         FUNC_REVERSE: begin
            if (held != 0) begin
               flipped = !flipped;
            end
         end
         default: begin
         end
      endcase

      // Both ends read zero on an empty queue.
      if (held == 0) begin
         view.front = '0;
         view.back  = '0;
      end else begin
         first = ring[head];
         last  = ring[(head + held - 1) % DEPTH];
         view.front = flipped ? last : first;
         view.back  = flipped ? first : last;
      end
      view.count = COUNT_WIDTH'(held);
      return view;
   endfunction

   // Predict on every accepted request transaction, compare on every accepted response.
   always @(posedge clock) begin
      deque_view_type want;
      if (reset) begin
         head = 0;
         held = 0;
         flipped = 1'b0;
         mismatches = 0;
         expected_views.delete();
      end else begin
         if (req_valid && !req_stall) begin
            expected_views.push_back(apply_operation(req_func, req_value));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_views.size() == 0) begin
               $error("response transaction with no request outstanding");
               mismatches++;
            end else begin
               want = expected_views.pop_front();
               if (rsp_front_value !== want.front) begin
                  $error("front_value: expected %h, actual %h", want.front, rsp_front_value);
                  mismatches++;
               end
               if (rsp_back_value !== want.back) begin
                  $error("back_value: expected %h, actual %h", want.back, rsp_back_value);
                  mismatches++;
               end
               if (rsp_element_count !== want.count) begin
                  $error("element_count: expected %0d, actual %0d", want.count,
                         rsp_element_count);
                  mismatches++;
               end
               if (rsp_error_code !== want.err_code) begin
                  $error("error_code: expected %0d, actual %0d", want.err_code,
                         rsp_error_code);
                  mismatches++;
               end
            end
         end
      end
      mismatch_count <= mismatches;
      outstanding <= expected_views.size();
   end

endmodule

// ----- sim/double_ended_queue_test.sv -----
// Drives request transactions into the double-ended queue, stalls the
// response side at random and gives the verdict from the checker's mismatch and outstanding counts.
module double_ended_queue_test;
   import dq_pkg::*;

   localparam int DEPTH          = 16;
   localparam int ELEM_WIDTH     = 64;
   localparam int COUNT_WIDTH    = $clog2(DEPTH + 1);
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int PHASE_COUNT    = 17;
   localparam int PHASE_ITEMS    = 100;
   localparam int QUIET_PHASES   = 3;
   localparam int DRAIN_CYCLES   = 8;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [2:0]             req_func = FUNC_PUSH_FRONT;
   logic [ELEM_WIDTH-1:0]  req_value = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [ELEM_WIDTH-1:0]  rsp_front_value;
   logic [ELEM_WIDTH-1:0]  rsp_back_value;
   logic [COUNT_WIDTH-1:0] rsp_element_count;
   logic [1:0]             rsp_error_code;

   int failures;
   int pending;
   int gap_pct = 0;
   int stall_pct = 0;
   int stall_left = 0;
   int idle_cycles;

   double_ended_queue #(
      .DEPTH(DEPTH),
      .ELEM_WIDTH(ELEM_WIDTH)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_func(req_func),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_front_value(rsp_front_value),
      .rsp_back_value(rsp_back_value),
      .rsp_element_count(rsp_element_count),
      .rsp_error_code(rsp_error_code)
   );

   double_ended_queue_checker #(
      .DEPTH(DEPTH),
      .ELEM_WIDTH(ELEM_WIDTH)
   ) i_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_func(req_func),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_front_value(rsp_front_value),
      .rsp_back_value(rsp_back_value),
      .rsp_element_count(rsp_element_count),
      .rsp_error_code(rsp_error_code),
      .mismatch_count(failures),
      .outstanding(pending)
   );

   always #5 clock = ~clock;

   // Response stalls come in bursts of random length; a new burst starts only after the stall has dropped.
   always @(posedge clock) begin
      if (reset || stall_pct == 0) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (rsp_stall) begin
         rsp_stall <= 1'b0;
      end else if ($urandom_range(99) < stall_pct) begin
         rsp_stall <= 1'b1;
         stall_left <= $urandom_range(3);
      end
   end

   // Sends one request transaction, possibly after a short gap, and waits for acceptance.
   task automatic issue(input logic [2:0] func, input logic [ELEM_WIDTH-1:0] value);
      if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= func;
      req_value <= value;
      do @(posedge clock); while (req_stall);
   endtask

   // Holds off the sender until every predicted response has arrived.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // Ends the run when nothing moves on either channel for too long.
   initial begin
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      logic [2:0]            func;
      logic [ELEM_WIDTH-1:0] value;
      int                    push_pct;
      int                    counted;
      int                    pick;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Operations on an empty queue, including the unused codes.
      issue(FUNC_POP_FRONT, '1);
      issue(FUNC_POP_BACK, '0);
      issue(FUNC_REVERSE, '1);
      issue(FUNC_REVERSE + 3'd1, '1);
      issue(FUNC_REVERSE + 3'd3, '0);

      // Fill from both ends with the value extremes, then overflow both ends, reverse and pop from both ends.
      for (int i = 0; i < DEPTH; i++) begin
         case (i)
            0:       value = '0;
            1:       value = '1;
            2:       value = {ELEM_WIDTH/2{2'b01}};
            3:       value = {ELEM_WIDTH/2{2'b10}};
            4:       value = {1'b1, {ELEM_WIDTH-2{1'b0}}, 1'b1};
            default: value = {$urandom, $urandom};
         endcase
         issue((i % 2 == 0) ? FUNC_PUSH_FRONT : FUNC_PUSH_BACK, value);
      end
      issue(FUNC_PUSH_FRONT, '1);
      issue(FUNC_PUSH_BACK, '1);
      issue(FUNC_REVERSE, '0);
      issue(FUNC_POP_FRONT, '0);
      issue(FUNC_POP_BACK, '0);
      wait_for_results();

      // Random phases alternate between filling and draining the queue, with every third phase balanced.
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         if (phase % 3 == 2) begin
            push_pct = 50;
         end else if (phase % 2 == 0) begin
            push_pct = $urandom_range(75, 90);
         end else begin
            push_pct = $urandom_range(10, 30);
         end
         if (phase >= PHASE_COUNT - QUIET_PHASES) begin
            gap_pct = 0;
            stall_pct <= 0;
         end else begin
            gap_pct = (phase % 4 == 3) ? 0 : $urandom_range(10, 40);
            stall_pct <= (phase % 4 == 1) ? 0 : $urandom_range(10, 50);
         end
         if (phase == PHASE_COUNT / 2) begin
            wait_for_results();
         end

         counted = 0;
         while (counted < PHASE_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 5) begin
               func = FUNC_REVERSE + 3'($urandom_range(1, 3));
            end else if (pick < 12) begin
               func = FUNC_REVERSE;
            end else if ($urandom_range(99) < push_pct) begin
               func = $urandom_range(1) ? FUNC_PUSH_BACK : FUNC_PUSH_FRONT;
            end else begin
               func = $urandom_range(1) ? FUNC_POP_BACK : FUNC_POP_FRONT;
            end
            case ($urandom_range(9))
               0:       value = '0;
               1:       value = '1;
               default: value = {$urandom, $urandom};
            endcase
            issue(func, value);
            if (func <= FUNC_REVERSE) begin
               counted++;
            end
         end
      end

      // Let the last responses drain, then give the verdict.
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0 && pending == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/dq_pkg.sv
hw/rtl/dq_ctrl.sv
hw/rtl/dq_datapath.sv
hw/rtl/double_ended_queue.sv
sim/double_ended_queue_checker.sv
sim/double_ended_queue_test.sv
